// ===== hdl/acl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_pkg: shared definitions for the account credit ledger
// Table geometry, opcode and status codes, payload structs, queue sizing and
// the saturating add used by the ledger update.
// ----------------------------------------------------------------------------
package acl_pkg;

  // Ledger geometry. The entry index is the low bits of the account id, so
  // the table depth stays a power of two.
  localparam int unsigned ACCOUNTS = 1024;
  localparam int unsigned IDX_W    = $clog2(ACCOUNTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACCOUNTS - 1);

  localparam logic [63:0] DEFAULT_AVAILABLE = 64'd1000000000000000;

  // Command queue between front and back; depth is a power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] Q_FULL_CNT = QCNT_W'(QDEPTH);

  // Opcodes on the input channel
  localparam logic [1:0] OPC_ACCEPT = 2'd0;
  localparam logic [1:0] OPC_FILL   = 2'd1;
  localparam logic [1:0] OPC_CANCEL = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_APPLIED   = 2'd0;
  localparam logic [1:0] STAT_REJECTED  = 2'd1;
  localparam logic [1:0] STAT_SHORTFALL = 2'd2;

  typedef enum logic [1:0] {
    CMD_ACCEPT,
    CMD_FILL,
    CMD_CANCEL,
    CMD_INVALID
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] acct_num;
    logic [63:0] cost;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] available_after;
    logic [63:0] reserved_after;
    logic [63:0] used_after;
    logic [63:0] exposure_after;
  } out_item_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [63:0]      cost;
  } cmd_t;

  // One ledger entry
  typedef struct packed {
    logic [63:0] available;
    logic [63:0] reserved;
    logic [63:0] used;
    logic [63:0] exposure;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/acl_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_front: input stage of the ledger
// Accepts order events, decodes the opcode and entry index, and hands the
// classified command to the queue.
// ----------------------------------------------------------------------------
module acl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire acl_pkg::in_item_t in_data,
  input  wire logic              clear_busy,
  input  wire acl_pkg::q_stat_t  q_stat,
  output logic                   busy,
  output logic                   push,
  output acl_pkg::cmd_t          push_cmd
);

  acl_pkg::cmd_t hold_r;
  logic          hold_vld_r;
  acl_pkg::cmd_t cmd_nxt;
  logic          accept;

  always_comb begin
    cmd_nxt.idx  = in_data.acct_num[acl_pkg::IDX_W-1:0];
    cmd_nxt.cost = in_data.cost;
    unique case (in_data.opcode)
      acl_pkg::OPC_ACCEPT: cmd_nxt.kind = acl_pkg::CMD_ACCEPT;
      acl_pkg::OPC_FILL:   cmd_nxt.kind = acl_pkg::CMD_FILL;
      acl_pkg::OPC_CANCEL: cmd_nxt.kind = acl_pkg::CMD_CANCEL;
      default:             cmd_nxt.kind = acl_pkg::CMD_INVALID;
    endcase
  end

  assign busy     = clear_busy | (hold_vld_r & q_stat.full);
  assign accept   = start & ~busy;
  assign push     = hold_vld_r & ~q_stat.full;
  assign push_cmd = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        hold_vld_r <= 1'b1;
        hold_r     <= cmd_nxt;
      end else if (push) begin
        hold_vld_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/acl_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_queue: command queue
// Short FIFO that decouples the front stage from the ledger back end.
// ----------------------------------------------------------------------------
module acl_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire acl_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output acl_pkg::cmd_t      head,
  output acl_pkg::q_stat_t   q_stat
);

  acl_pkg::cmd_t                q_mem_r [acl_pkg::QDEPTH];
  logic [acl_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [acl_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [acl_pkg::QCNT_W-1:0]   count_r;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.full  = (count_r == acl_pkg::Q_FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign head         = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/acl_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_back: ledger back end
// Holds the ledger table, clears it after reset, and runs one read-modify-
// write per command (idle, eval, resolve) and drives the registered result.
// ----------------------------------------------------------------------------
module acl_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acl_pkg::cmd_t    head,
  input  wire acl_pkg::q_stat_t q_stat,
  output logic                  pop,
  output acl_pkg::back_stat_t   back_stat,
  output logic                  out_strobe,
  output acl_pkg::out_item_t    out_data
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_RESOLVE
  } state_t;

  acl_pkg::entry_t            ledger_mem [acl_pkg::ACCOUNTS];
  acl_pkg::entry_t            rd_data_r;
  logic                       wr_en;
  logic [acl_pkg::IDX_W-1:0]  wr_addr;
  acl_pkg::entry_t            wr_data;

  state_t                     state_r;
  logic [acl_pkg::IDX_W-1:0]  clr_idx_r;
  acl_pkg::cmd_t              cmd_r;

  // first evaluation step results
  logic                       ge_av_r;
  logic                       ge_rs_r;
  logic [63:0]                av_sub_r;
  logic [63:0]                rs_sub_r;
  logic [63:0]                rs_add_r;
  logic [63:0]                av_add_r;
  logic [63:0]                short_r;
  logic [63:0]                used_add_r;
  logic [63:0]                expo_add_r;

  acl_pkg::entry_t            res_entry;
  logic [1:0]                 res_status;
  logic                       out_strobe_r;
  acl_pkg::out_item_t         out_data_r;

  assign pop                = (state_r == ST_IDLE) & ~q_stat.empty;
  assign back_stat.clearing = (state_r == ST_CLEAR);
  assign out_strobe         = out_strobe_r;
  assign out_data           = out_data_r;

  // Second step: cover a fill shortfall from available, then pick the update.
  always_comb begin
    res_entry  = rd_data_r;
    res_status = acl_pkg::STAT_APPLIED;
    unique case (cmd_r.kind)
      acl_pkg::CMD_ACCEPT: begin
        if (ge_av_r) begin
          res_entry.available = av_sub_r;
          res_entry.reserved  = rs_add_r;
        end else begin
          res_status = acl_pkg::STAT_REJECTED;
        end
      end
      acl_pkg::CMD_FILL: begin
        res_entry.used     = used_add_r;
        res_entry.exposure = expo_add_r;
        if (ge_rs_r) begin
          res_entry.reserved = rs_sub_r;
        end else begin
          res_entry.reserved = '0;
          if (rd_data_r.available >= short_r) begin
            res_entry.available = rd_data_r.available - short_r;
          end else begin
            res_status = acl_pkg::STAT_SHORTFALL;
          end
        end
      end
      acl_pkg::CMD_CANCEL: begin
        if (ge_rs_r) begin
          res_entry.reserved  = rs_sub_r;
          res_entry.available = av_add_r;
        end else begin
          res_status = acl_pkg::STAT_REJECTED;
        end
      end
      default: begin
        res_status = acl_pkg::STAT_REJECTED;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_r.idx;
    wr_data = res_entry;
    if (state_r == ST_CLEAR) begin
      wr_en             = 1'b1;
      wr_addr           = clr_idx_r;
      wr_data.available = acl_pkg::DEFAULT_AVAILABLE;
      wr_data.reserved  = '0;
      wr_data.used      = '0;
      wr_data.exposure  = '0;
    end else if (state_r == ST_RESOLVE) begin
      wr_en = 1'b1;
    end
  end

  // Ledger table: one write port, one registered read port at the queue head.
  // Hold the read data for the whole command once the head is popped.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ledger_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      rd_data_r <= ledger_mem[head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == acl_pkg::LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cmd_r   <= head;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          ge_av_r    <= rd_data_r.available >= cmd_r.cost;
          ge_rs_r    <= rd_data_r.reserved >= cmd_r.cost;
          av_sub_r   <= rd_data_r.available - cmd_r.cost;
          rs_sub_r   <= rd_data_r.reserved - cmd_r.cost;
          rs_add_r   <= acl_pkg::sat_add(rd_data_r.reserved, cmd_r.cost);
          av_add_r   <= acl_pkg::sat_add(rd_data_r.available, cmd_r.cost);
          short_r    <= cmd_r.cost - rd_data_r.reserved;
          used_add_r <= acl_pkg::sat_add(rd_data_r.used, cmd_r.cost);
          expo_add_r <= acl_pkg::sat_add(rd_data_r.exposure, cmd_r.cost);
          state_r    <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          out_strobe_r               <= 1'b1;
          out_data_r.status          <= res_status;
          out_data_r.available_after <= res_entry.available;
          out_data_r.reserved_after  <= res_entry.reserved;
          out_data_r.used_after      <= res_entry.used;
          out_data_r.exposure_after  <= res_entry.exposure;
          state_r                    <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/account_credit_ledger.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// account_credit_ledger: per-account credit ledger for pre-trade risk
// Applies accept, fill and cancel events to a table of account entries and
// reports the status and the entry's amounts after each update.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start / busy       | in_data  (opcode, acct_num, cost)
//   result   | out_strobe         | out_data (status, available, reserved,
//            |                    |           used, exposure after update)
//
// An event is transferred on a rising edge with start high and busy low.
// The back end handles each event in order: pop and table read, first compare
// and add step, then shortfall step and write-back; the table's single
// read-modify-write pops no new event until the last one is written back.
// Results register as the entry is written back, shown for exactly one cycle.
// After reset a clearing pass writes all 1024 entries, one per cycle, and
// busy stays high until the pass ends.
// The front stage and a 2-entry queue absorb a few events while the back end
// works; busy also rises when they are full. The receiver cannot stall.
// ----------------------------------------------------------------------------
module account_credit_ledger (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire acl_pkg::in_item_t in_data,
  output logic                   out_strobe,
  output acl_pkg::out_item_t     out_data
);

  acl_pkg::q_stat_t     q_stat;
  acl_pkg::back_stat_t  back_stat;
  acl_pkg::cmd_t        push_cmd;
  acl_pkg::cmd_t        head;
  logic                 push;
  logic                 pop;

  // Decode and hold the incoming event until the queue has room.
  acl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .clear_busy (back_stat.clearing),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Buffer classified commands between front and back.
  acl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Clear the table, then update one entry per command and emit the result.
  acl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .back_stat  (back_stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== verif/tb_acl_ledger_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_acl_ledger_pkg: ledger mirror for the account credit ledger bench
// Keeps a shadow copy of the four per-account tables and the results still
// owed by the block. Each input transfer is applied to the shadow tables, and
// each output transfer is compared with the oldest owed result.
// ----------------------------------------------------------------------------
package tb_acl_ledger_pkg;
  import acl_pkg::*;

  // The block treats the fourth opcode value as undefined
  localparam logic [1:0] OPC_UNDEFINED = 2'd3;

  class ledger_mirror;
    logic [63:0] avail_tbl [ACCOUNTS];
    logic [63:0] resv_tbl  [ACCOUNTS];
    logic [63:0] used_tbl  [ACCOUNTS];
    logic [63:0] expo_tbl  [ACCOUNTS];
    out_item_t   due_results [$];
    int unsigned mismatch_count;

    function new();
      for (int i = 0; i < ACCOUNTS; i++) begin
        avail_tbl[i] = DEFAULT_AVAILABLE;
        resv_tbl[i]  = '0;
        used_tbl[i]  = '0;
        expo_tbl[i]  = '0;
      end
      mismatch_count = 0;
    endfunction

    // Clamp at all ones when the sum carries out
    static function logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[64] ? {64{1'b1}} : wide[63:0];
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // Apply one accepted order event to the shadow tables
    function void note_transfer(in_item_t item);
      int unsigned idx;
      logic [63:0] avail, resv, used, expo, gap;
      out_item_t   want;
      idx   = item.acct_num % ACCOUNTS;
      avail = avail_tbl[idx];
      resv  = resv_tbl[idx];
      used  = used_tbl[idx];
      expo  = expo_tbl[idx];
      want.status = STAT_APPLIED;
      case (item.opcode)
        OPC_ACCEPT: begin
          if (avail >= item.cost) begin
            avail = avail - item.cost;
            resv  = clip_add(resv, item.cost);
          end else begin
            want.status = STAT_REJECTED;
          end
        end
        OPC_FILL: begin
          if (resv >= item.cost) begin
            resv = resv - item.cost;
          end else begin
            gap  = item.cost - resv;
            resv = '0;
            if (avail >= gap) avail = avail - gap;
            else want.status = STAT_SHORTFALL;
          end
          used = clip_add(used, item.cost);
          expo = clip_add(expo, item.cost);
        end
        OPC_CANCEL: begin
          if (resv >= item.cost) begin
            resv  = resv - item.cost;
            avail = clip_add(avail, item.cost);
          end else begin
            want.status = STAT_REJECTED;
          end
        end
        default: begin
          want.status = STAT_REJECTED;
        end
      endcase
      avail_tbl[idx] = avail;
      resv_tbl[idx]  = resv;
      used_tbl[idx]  = used;
      expo_tbl[idx]  = expo;
      want.available_after = avail;
      want.reserved_after  = resv;
      want.used_after      = used;
      want.exposure_after  = expo;
      due_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing owed: status %0d available %0d reserved %0d",
               got.status, got.available_after, got.reserved_after);
        mismatch_count++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status",          64'(want.status),     64'(got.status));
      compare_field("available_after", want.available_after, got.available_after);
      compare_field("reserved_after",  want.reserved_after,  got.reserved_after);
      compare_field("used_after",      want.used_after,      got.used_after);
      compare_field("exposure_after",  want.exposure_after,  got.exposure_after);
    endfunction

    function void flag_leftovers();
      if (due_results.size() != 0) begin
        $error("%0d results never arrived", due_results.size());
        mismatch_count++;
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_account_credit_ledger.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_account_credit_ledger: self-checking bench for the account credit ledger
// Drives order events through the start/busy port, mirrors every accepted
// event in a shadow ledger and checks each strobed result field by field.
// A directed opening covers zero cost, exact coverage, shortfall, saturation,
// the undefined opcode and account aliasing; random phases follow with
// varying sender idle rates.
// ----------------------------------------------------------------------------
module tb_account_credit_ledger;
  import acl_pkg::*;
  import tb_acl_ledger_pkg::*;

  localparam logic [63:0] ALL_ONES         = {64{1'b1}};
  localparam int unsigned RANDOM_PER_PHASE = 283;
  // Sender idle chance per cycle in each random phase
  localparam int unsigned IDLE_PCT [4]     = '{0, 84, 22, 0};
  localparam int unsigned DRAIN_CYCLES     = 20;
  // Roughly forty times the slowest expected run, clearing pass included
  localparam int unsigned RUN_LIMIT_NS     = 1_000_000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  ledger_mirror ledger;

  account_credit_ledger u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every strobed result; the strobe lasts one cycle, so sample each edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) ledger.check_result(out_data);
  end

  function automatic in_item_t order_event(logic [1:0] op, logic [31:0] id,
                                           logic [63:0] cost);
    in_item_t item;
    item.opcode   = op;
    item.acct_num = id;
    item.cost     = cost;
    return item;
  endfunction

  // Bias toward a handful of entries so that events close together hit the
  // same account and read back freshly written amounts
  function automatic logic [31:0] pick_account();
    logic [31:0] id;
    id = $urandom;
    if ($urandom_range(0, 99) < 70) id[IDX_W-1:0] = IDX_W'($urandom_range(0, 7));
    return id;
  endfunction

  // Aim costs at the entry's current amounts so that both sides of every
  // comparison come up often
  function automatic logic [63:0] pick_cost(int unsigned idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 64'($urandom_range(0, 1 << 20));
    if (r < 55) return ledger.resv_tbl[idx] + 64'($urandom_range(0, 2)) - 64'd1;
    if (r < 75) return ledger.avail_tbl[idx] + 64'($urandom_range(0, 2)) - 64'd1;
    if (r < 85) return {$urandom, $urandom};
    if (r < 95) return DEFAULT_AVAILABLE >> $urandom_range(0, 24);
    return ~64'($urandom_range(0, 3));
  endfunction

  function automatic in_item_t next_random_event();
    in_item_t    item;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)       item.opcode = OPC_UNDEFINED;
    else if (r < 40) item.opcode = OPC_ACCEPT;
    else if (r < 70) item.opcode = OPC_FILL;
    else             item.opcode = OPC_CANCEL;
    item.acct_num = pick_account();
    item.cost     = pick_cost(item.acct_num % ACCOUNTS);
    return item;
  endfunction

  // Idle for a random number of cycles with junk on the data bus, then hold
  // the event until busy is low at an edge. Start stays high on return so
  // the next event can follow without a bubble.
  task automatic send_event(input in_item_t item, input int unsigned idle_pct);
    in_item_t junk;
    while ($urandom_range(0, 99) < idle_pct) begin
      junk.opcode   = 2'($urandom);
      junk.acct_num = $urandom;
      junk.cost     = {$urandom, $urandom};
      start   <= 1'b0;
      in_data <= junk;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_transfer(item);
  endtask

  initial begin
    ledger  = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero cost on every defined opcode: accept and cancel apply, fill is a no-op
    send_event(order_event(OPC_ACCEPT, 32'd0, 64'd0), 0);
    send_event(order_event(OPC_FILL,   32'd0, 64'd0), 0);
    send_event(order_event(OPC_CANCEL, 32'd0, 64'd0), 0);
    // Reserve exactly the full default, then overdraw and overcancel
    send_event(order_event(OPC_ACCEPT, 32'd1, DEFAULT_AVAILABLE), 0);
    send_event(order_event(OPC_ACCEPT, 32'd1, 64'd1), 0);
    send_event(order_event(OPC_CANCEL, 32'd1, DEFAULT_AVAILABLE + 64'd1), 0);
    send_event(order_event(OPC_CANCEL, 32'd1, DEFAULT_AVAILABLE), 0);
    send_event(order_event(OPC_ACCEPT, 32'd2, ALL_ONES), 0);
    // Fill with nothing reserved draws the whole cost from available
    send_event(order_event(OPC_FILL, 32'd3, 64'd500), 0);
    // Uncovered shortfall, then saturate used and exposure
    send_event(order_event(OPC_FILL, 32'd4, ALL_ONES), 0);
    send_event(order_event(OPC_FILL, 32'd4, 64'd1), 0);
    send_event(order_event(OPC_UNDEFINED, 32'd5, {$urandom, $urandom}), 0);
    send_event(order_event(OPC_UNDEFINED, 32'd4, ALL_ONES), 0);
    // Highest id lands on the last entry; id 1024 aliases entry zero
    send_event(order_event(OPC_ACCEPT, 32'hFFFF_FFFF, 64'd7), 0);
    send_event(order_event(OPC_ACCEPT, 32'd1024, 64'd3), 0);
    send_event(order_event(OPC_CANCEL, 32'hFFFF_FC00, 64'd3), 0);
    // Fill partly covered by reserved, rest from available
    send_event(order_event(OPC_ACCEPT, 32'd6, 64'd100), 0);
    send_event(order_event(OPC_FILL,   32'd6, 64'd150), 0);
    // Fill fully covered by reserved
    send_event(order_event(OPC_ACCEPT, 32'd7, 64'd100), 0);
    send_event(order_event(OPC_FILL,   32'd7, 64'd40), 0);
    // Shortfall exactly equal to available, then one tick over
    send_event(order_event(OPC_FILL, 32'd8, DEFAULT_AVAILABLE), 0);
    send_event(order_event(OPC_FILL, 32'd8, 64'd1), 0);

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_event(next_random_event(), IDLE_PCT[p]);
      end
    end

    // Release the port and let every owed result arrive
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    ledger.flag_leftovers();
    if (ledger.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/acl_pkg.sv
hdl/acl_front.sv
hdl/acl_queue.sv
hdl/acl_back.sv
hdl/account_credit_ledger.sv
verif/tb_acl_ledger_pkg.sv
verif/tb_account_credit_ledger.sv
